/* rtl/core/lcch_pkg.sv */
`default_nettype none

package lcch_pkg;

  localparam int COLUMNS = 64;
  localparam int LINE_BYTES = 511;

  localparam int COL_W = $clog2(COLUMNS);
  localparam int LEN_W = $clog2(LINE_BYTES + 1);
  localparam int IDX_W = $clog2(LINE_BYTES);

  // Division by three as a multiplication by a rounded-up reciprocal.
  localparam int DIV3_SHIFT = LEN_W + 2;
  localparam int MUL_W = DIV3_SHIFT - 1;
  localparam int DIV3_MUL = ((1 << DIV3_SHIFT) + 2) / 3;
  localparam int PROD_W = LEN_W + MUL_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic   push;
    color_t color;
  } q_wr_t;

  typedef struct packed {
    logic   valid;
    color_t color;
  } q_rd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_READ,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/core/lcch_front.sv */
`default_nettype none

module lcch_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [7:0]      char_byte,
  input  wire logic            line_end,
  input  wire logic            q_full,
  output lcch_pkg::q_wr_t      q_wr
);
  import lcch_pkg::*;

  front_state_t state, state_next;

  logic [LEN_W-1:0]  line_count;
  logic [7:0]        running_sum;
  logic [7:0]        prefix_sums [LINE_BYTES];

  logic [LEN_W-1:0]  len_q;
  logic [7:0]        sum_q;
  logic [IDX_W-1:0]  addr1;
  logic [IDX_W-1:0]  addr2;
  logic              third_zero;
  logic [7:0]        p1_raw;
  logic [7:0]        p2_raw;

  logic              accept;
  logic              fill;
  logic              close;
  logic [7:0]        sum_add;
  logic [PROD_W-1:0] prod;
  logic [LEN_W-1:0]  third;
  logic [7:0]        p1;
  logic [7:0]        p2;

  assign accept  = start && (state == F_IDLE);
  assign sum_add = running_sum + char_byte;
  assign fill    = (line_count == LEN_W'(LINE_BYTES - 1));
  assign close   = accept && (line_end || fill);

  assign prod  = PROD_W'(len_q) * PROD_W'(DIV3_MUL);
  assign third = LEN_W'(prod >> DIV3_SHIFT);

  assign p1 = third_zero ? 8'd0 : p1_raw;
  assign p2 = third_zero ? 8'd0 : p2_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    busy            = 1'b1;
    q_wr.push       = 1'b0;
    q_wr.color.red   = p1;
    q_wr.color.green = p2 - p1;
    q_wr.color.blue  = sum_q - p2;
    unique case (state)
      F_IDLE: begin
        busy = 1'b0;
        if (close) begin
          state_next = F_CALC;
        end
      end
      F_CALC: begin
        state_next = F_READ;
      end
      F_READ: begin
        state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          q_wr.push  = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count  <= '0;
      running_sum <= '0;
    end else if (accept) begin
      if (close) begin
        line_count  <= '0;
        running_sum <= '0;
      end else begin
        line_count  <= line_count + LEN_W'(1);
        running_sum <= sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !line_end) begin
      prefix_sums[line_count[IDX_W-1:0]] <= sum_add;
    end
    if (close) begin
      len_q <= line_end ? line_count : line_count + LEN_W'(1);
      sum_q <= line_end ? running_sum : sum_add;
    end
    if (state == F_CALC) begin
      third_zero <= (third == '0);
      addr1      <= IDX_W'(third - LEN_W'(1));
      addr2      <= IDX_W'((third << 1) - LEN_W'(1));
    end
    p1_raw <= prefix_sums[addr1];
    p2_raw <= prefix_sums[addr2];
  end

endmodule

`default_nettype wire

/* rtl/core/lcch_queue.sv */
`default_nettype none

module lcch_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lcch_pkg::q_wr_t  q_wr,
  output logic                  full,
  input  wire logic             pop,
  output lcch_pkg::q_rd_t       q_rd
);
  import lcch_pkg::*;

  color_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push_ok;
  logic              pop_ok;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_rd.valid = (count != '0);
  assign q_rd.color = slots[rd_ptr];
  assign push_ok    = q_wr.push && !full;
  assign pop_ok     = pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= q_wr.color;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lcch_back.sv */
`default_nettype none

module lcch_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire lcch_pkg::q_rd_t         q_rd,
  output logic                         pop,
  output logic                         strobe,
  output logic [lcch_pkg::COL_W-1:0]   column,
  output logic [7:0]                   red,
  output logic [7:0]                   green,
  output logic [7:0]                   blue,
  output logic                         last_column
);
  import lcch_pkg::*;

  back_state_t state, state_next;

  logic [COL_W-1:0]   cnt;
  logic [COL_W-1:0]   head;
  logic [COL_W-1:0]   ridx;
  logic [COL_W-1:0]   raddr;
  logic [COL_W-1:0]   head_inc;
  logic [COL_W-1:0]   ridx_dec;
  color_t             ring [COLUMNS];
  logic [COLUMNS-1:0] ring_valid;
  color_t             rdata;
  logic               rvalid;

  assign head_inc = (head == COL_W'(COLUMNS - 1)) ? '0 : head + COL_W'(1);
  assign ridx_dec = (ridx == '0) ? COL_W'(COLUMNS - 1) : ridx - COL_W'(1);

  assign column      = cnt;
  assign last_column = (cnt == COL_W'(COLUMNS - 1));
  assign red         = rvalid ? rdata.red : 8'd0;
  assign green       = rvalid ? rdata.green : 8'd0;
  assign blue        = rvalid ? rdata.blue : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    strobe     = 1'b0;
    raddr      = ridx_dec;
    unique case (state)
      B_IDLE: begin
        raddr = head_inc;
        if (q_rd.valid) begin
          pop        = 1'b1;
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        strobe = 1'b1;
        if (last_column) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      head       <= '0;
      ring_valid <= '0;
    end else begin
      if (pop) begin
        head             <= head_inc;
        ring_valid[head] <= 1'b1;
        cnt              <= '0;
      end else if (strobe) begin
        cnt <= cnt + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ring[head] <= q_rd.color;
    end
    rdata  <= ring[raddr];
    rvalid <= ring_valid[raddr];
    ridx   <= raddr;
  end

endmodule

`default_nettype wire

/* rtl/core/line_checksum_color_history_top.sv */
// A byte item leaves busy low; a line close holds busy high through CALC, READ and PUSH,
// longer in PUSH only while both queue slots hold closed lines not yet drawn.
// A closed line passes CALC, READ and PUSH into the queue; the back end pops it when idle and
// draws one column per cycle over all 64 columns, reading the color ring through its one read port.
// Synchronous reset clears the line state, the ring head and the ring valid bits, so the
// ring reads black; the prefix sum memory is not cleared and needs no clearing pass.
`default_nettype none

module line_checksum_color_history_top (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [7:0]              char_byte,
  input  wire logic                    line_end,
  output logic                         strobe,
  output logic [lcch_pkg::COL_W-1:0]   column,
  output logic [7:0]                   red,
  output logic [7:0]                   green,
  output logic [7:0]                   blue,
  output logic                         last_column
);
  import lcch_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  pop;

  lcch_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .char_byte (char_byte),
    .line_end  (line_end),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  lcch_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .full (q_full),
    .pop  (pop),
    .q_rd (q_rd)
  );

  lcch_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_rd        (q_rd),
    .pop         (pop),
    .strobe      (strobe),
    .column      (column),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last_column (last_column)
  );

`ifndef SYNTH
  a_close_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && line_end |=> busy)
    else $error("line close transaction did not raise busy");

  a_frame_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_column |=> strobe && (column == COL_W'($past(column) + COL_W'(1))))
    else $error("frame columns are not contiguous");

  a_frame_starts_clean: assert property (@(posedge clk) disable iff (rst)
    strobe && (column == '0) |-> !$past(strobe) || $past(last_column))
    else $error("frame started inside another frame");

  a_push_only_when_room: assert property (@(posedge clk) disable iff (rst)
    q_wr.push |-> !q_full)
    else $error("queue push while full");
`endif

endmodule

`default_nettype wire
